// ----- sv/srt_pkg.sv -----
`timescale 1ns / 1ps

package srt_pkg;

  localparam int ID_W   = 16;
  localparam int NAME_W = 64;
  localparam int SEX_W  = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_RANGE     = 3'd5,
    ST_UNUSED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NAME_W-1:0] name;
    logic [SEX_W-1:0]  sex;
  } record_t;

endpackage

// ----- sv/sorted_record_table_unit.sv -----
`timescale 1ns / 1ps
// Sorted record table. Records are kept in ascending id order in a memory with
// one write port and one registered read port, so every pass over the table
// moves one entry per cycle. An item is taken when start is high and busy is
// low, and its single result shows on the result ports for one cycle with
// strobe high; that cycle must be captured, since the block cannot be held
// off. A read goes through S_READ and returns the registered read data. An
// insert scans the table for duplicates and for its slot in S_SCAN and, if it
// is neither a duplicate nor full, shifts later entries up in S_SHIFT_UP and
// writes the new record into its slot. A delete shifts later entries down.
// Out-of-range and unused commands answer in the next cycle without going busy.

module sorted_record_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [15:0] new_id,
  input  logic [63:0] new_name,
  input  logic [7:0]  new_sex,
  input  logic [3:0]  index,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [4:0]  count,
  output logic [15:0] out_id,
  output logic [63:0] out_name,
  output logic [7:0]  out_sex
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  srt_pkg::state_t  state, state_next;
  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    ptr_dec;
  logic [CW-1:0]    pos, pos_next;
  logic             found, found_next;
  logic             dup, dup_next;
  logic             pend, pend_next;
  logic [AW-1:0]    pend_addr, pend_addr_next;
  srt_pkg::record_t rec, rec_next;

  logic             issue;
  logic             accept;
  logic             in_range;
  logic             res_fire;
  logic             res_rd;
  srt_pkg::status_t res_status;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  srt_pkg::record_t wdata;
  srt_pkg::record_t rdata;

  srt_mem #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy     = (state != srt_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign in_range = CMPW'(index) < CMPW'(fill);
  assign ptr_dec  = ptr - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= srt_pkg::S_IDLE;
      fill   <= '0;
      pend   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      pend   <= pend_next;
      strobe <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pos       <= pos_next;
    found     <= found_next;
    dup       <= dup_next;
    pend_addr <= pend_addr_next;
    rec       <= rec_next;
    if (res_fire) begin
      status   <= res_status;
      count    <= 5'(fill_next);
      out_id   <= res_rd ? rdata.id : '0;
      out_name <= res_rd ? rdata.name : '0;
      out_sex  <= res_rd ? rdata.sex : '0;
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    ptr_next       = ptr;
    pos_next       = pos;
    found_next     = found;
    dup_next       = dup;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    rec_next       = rec;
    issue          = 1'b0;
    raddr          = ptr[AW-1:0];
    we             = 1'b0;
    waddr          = pend_addr;
    wdata          = rdata;
    res_fire       = 1'b0;
    res_rd         = 1'b0;
    res_status     = srt_pkg::ST_INSERTED;

    case (state)
      srt_pkg::S_IDLE: begin
        if (accept) begin
          case (srt_pkg::cmd_t'(cmd))
            srt_pkg::CMD_INSERT: begin
              rec_next   = '{id: new_id, name: new_name, sex: new_sex};
              ptr_next   = '0;
              pos_next   = fill;
              found_next = 1'b0;
              dup_next   = 1'b0;
              state_next = srt_pkg::S_SCAN;
            end
            srt_pkg::CMD_DELETE: begin
              if (in_range) begin
                ptr_next   = CW'(index) + 1'b1;
                state_next = srt_pkg::S_SHIFT_DN;
              end else begin
                res_fire   = 1'b1;
                res_status = srt_pkg::ST_RANGE;
              end
            end
            srt_pkg::CMD_READ: begin
              if (in_range) begin
                raddr      = AW'(index);
                state_next = srt_pkg::S_READ;
              end else begin
                res_fire   = 1'b1;
                res_status = srt_pkg::ST_RANGE;
              end
            end
            default: begin
              res_fire   = 1'b1;
              res_status = srt_pkg::ST_UNUSED;
            end
          endcase
        end
      end

      srt_pkg::S_SCAN: begin
        issue = ptr < fill;
        raddr = ptr[AW-1:0];
        if (issue) begin
          ptr_next       = ptr + 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
        end
        if (pend) begin
          if (rdata == rec) begin
            dup_next = 1'b1;
          end
          if (!found && rdata.id > rec.id) begin
            found_next = 1'b1;
            pos_next   = CW'(pend_addr);
          end
        end
        if (!issue && !pend) begin
          if (dup) begin
            res_fire   = 1'b1;
            res_status = srt_pkg::ST_DUPLICATE;
            state_next = srt_pkg::S_IDLE;
          end else if (fill == CW'(TABLE_DEPTH)) begin
            res_fire   = 1'b1;
            res_status = srt_pkg::ST_FULL;
            state_next = srt_pkg::S_IDLE;
          end else begin
            ptr_next   = fill;
            state_next = srt_pkg::S_SHIFT_UP;
          end
        end
      end

      srt_pkg::S_SHIFT_UP: begin
        issue = ptr > pos;
        raddr = ptr_dec[AW-1:0];
        if (issue) begin
          ptr_next       = ptr_dec;
          pend_next      = 1'b1;
          pend_addr_next = ptr_dec[AW-1:0];
        end
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr + 1'b1;
          wdata = rdata;
        end
        if (!issue && !pend) begin
          we         = 1'b1;
          waddr      = pos[AW-1:0];
          wdata      = rec;
          fill_next  = fill + 1'b1;
          res_fire   = 1'b1;
          res_status = srt_pkg::ST_INSERTED;
          state_next = srt_pkg::S_IDLE;
        end
      end

      srt_pkg::S_SHIFT_DN: begin
        issue = ptr < fill;
        raddr = ptr[AW-1:0];
        if (issue) begin
          ptr_next       = ptr + 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
        end
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr - 1'b1;
          wdata = rdata;
        end
        if (!issue && !pend) begin
          fill_next  = fill - 1'b1;
          res_fire   = 1'b1;
          res_status = srt_pkg::ST_DELETED;
          state_next = srt_pkg::S_IDLE;
        end
      end

      srt_pkg::S_READ: begin
        res_fire   = 1'b1;
        res_rd     = 1'b1;
        res_status = srt_pkg::ST_READ_OK;
        state_next = srt_pkg::S_IDLE;
      end

      default: begin
        state_next = srt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/srt_mem.sv -----
`timescale 1ns / 1ps

module srt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  srt_pkg::record_t  wdata,
  input  logic [AW-1:0]     raddr,
  output srt_pkg::record_t  rdata
);

  srt_pkg::record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/srt_checker.sv -----
`timescale 1ns / 1ps

module srt_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd,
  input logic        strobe,
  input logic [2:0]  status,
  input logic [4:0]  count,
  input logic [15:0] out_id,
  input logic [63:0] out_name,
  input logic [7:0]  out_sex
);

  localparam logic [4:0] FULL_COUNT = 5'(TABLE_DEPTH);

  assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result shown while busy");

  assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == srt_pkg::CMD_UNUSED |=>
      strobe && status == srt_pkg::ST_UNUSED)
    else $error("unused command not answered");

  assert property (@(posedge clk) disable iff (rst)
    strobe && status != srt_pkg::ST_READ_OK |-> out_id == '0 && out_name == '0 && out_sex == '0)
    else $error("record fields not zero outside a read");

  assert property (@(posedge clk) disable iff (rst)
    strobe && status == srt_pkg::ST_FULL |-> count == FULL_COUNT)
    else $error("full status with table not full");

  assert property (@(posedge clk) disable iff (rst)
    strobe && status == srt_pkg::ST_INSERTED |-> count != '0)
    else $error("insert left an empty table");

endmodule

bind sorted_record_table_unit srt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_srt_checker (.*);
